// ===== rtl/qte_pkg.sv =====
// shared types, constants and the arctangent table for the quaternion to euler block
// no dependencies
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int STAGES_USED = (CORDIC_STAGES > 24) ? 24 :
                               ((CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES);

  localparam int OP_W = 34;     // width of atan2 operands at q2.30
  localparam int ANG_W = 35;    // angle accumulator at q2.30
  localparam int XY_W = 38;     // cordic datapath, room for gain
  localparam int RAD_W = 62;    // square root radicand and remainder
  localparam int SQRT_STEPS = 31;

  localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [OP_W-1:0] AS_CLAMP_HI = 34'sd1073731087;
  localparam logic signed [OP_W-1:0] AS_CLAMP_LO = -34'sd1073741824;
  localparam logic [RAD_W-1:0] ONE_Q60 = 62'd1 << 60;
  localparam logic signed [18:0] ANG_LIMIT = 19'sd25736;
  localparam logic signed [18:0] PITCH_LIMIT = 19'sd12868;

  typedef struct packed {
    logic signed [OP_W-1:0] yaw_n;
    logic signed [OP_W-1:0] yaw_d;
    logic signed [OP_W-1:0] roll_n;
    logic signed [OP_W-1:0] roll_d;
    logic signed [OP_W-1:0] s;
  } qte_ops_t;

  // truncated atan(2^-i) at q2.30
  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0: r = 35'sd843314856;
      1: r = 35'sd497837829;
      2: r = 35'sd263043836;
      3: r = 35'sd133525158;
      4: r = 35'sd67021686;
      5: r = 35'sd33543515;
      6: r = 35'sd16775850;
      7: r = 35'sd8388437;
      8: r = 35'sd4194282;
      9: r = 35'sd2097149;
      10: r = 35'sd1048575;
      11: r = 35'sd524287;
      12: r = 35'sd262143;
      13: r = 35'sd131071;
      14: r = 35'sd65535;
      15: r = 35'sd32767;
      16: r = 35'sd16383;
      17: r = 35'sd8191;
      18: r = 35'sd4095;
      19: r = 35'sd2047;
      20: r = 35'sd1023;
      21: r = 35'sd511;
      22: r = 35'sd255;
      23: r = 35'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/qte_front.sv =====
// front end: products, atan2 operands, clamped sine term and square root radicand
// depends on qte_pkg
module qte_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        vin,
  input  logic signed [15:0]          qw,
  input  logic signed [15:0]          qx,
  input  logic signed [15:0]          qy,
  input  logic signed [15:0]          qz,
  output logic                        vout,
  output logic [qte_pkg::RAD_W-1:0]   rad,
  output qte_pkg::qte_ops_t           ops
);

  logic v1, v2;
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_yz, p_wx, p_xz, p_wy;
  qte_pkg::qte_ops_t ops2, ops2_next;
  logic signed [qte_pkg::OP_W-1:0] s_raw;
  logic signed [63:0] sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vout <= 1'b0;
    end else begin
      v1 <= vin;
      v2 <= v1;
      vout <= v2;
    end
  end

  // stage 1: all ten products
  always_ff @(posedge clk) begin
    p_ww <= qw * qw;
    p_xx <= qx * qx;
    p_yy <= qy * qy;
    p_zz <= qz * qz;
    p_xy <= qx * qy;
    p_wz <= qw * qz;
    p_yz <= qy * qz;
    p_wx <= qw * qx;
    p_xz <= qx * qz;
    p_wy <= qw * qy;
  end

  // stage 2: sums, sine term clamped into [-1, 0.99999]
  always_comb begin
    ops2_next.yaw_n = (34'(p_xy) + 34'(p_wz)) <<< 1;
    ops2_next.yaw_d = 34'(p_ww) + 34'(p_xx) - 34'(p_yy) - 34'(p_zz);
    ops2_next.roll_n = (34'(p_yz) + 34'(p_wx)) <<< 1;
    ops2_next.roll_d = 34'(p_ww) - 34'(p_xx) - 34'(p_yy) + 34'(p_zz);
    s_raw = (34'(p_wy) - 34'(p_xz)) <<< 1;
    if (s_raw > qte_pkg::AS_CLAMP_HI) begin
      ops2_next.s = qte_pkg::AS_CLAMP_HI;
    end else if (s_raw < qte_pkg::AS_CLAMP_LO) begin
      ops2_next.s = qte_pkg::AS_CLAMP_LO;
    end else begin
      ops2_next.s = s_raw;
    end
  end

  always_ff @(posedge clk) begin
    ops2 <= ops2_next;
  end

  // stage 3: radicand 1 - s^2 at q2.60
  assign sq = $signed(ops2.s[31:0]) * $signed(ops2.s[31:0]);

  always_ff @(posedge clk) begin
    rad <= qte_pkg::ONE_Q60 - sq[qte_pkg::RAD_W-1:0];
    ops <= ops2;
  end

endmodule

// ===== rtl/qte_sqrt.sv =====
// pipelined floor square root, one result bit per stage, side operands ride along
// depends on qte_pkg
module qte_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        vin,
  input  logic [qte_pkg::RAD_W-1:0]   rad,
  input  qte_pkg::qte_ops_t           ops_in,
  output logic                        vout,
  output logic signed [qte_pkg::OP_W-1:0] root_out,
  output qte_pkg::qte_ops_t           ops_out
);

  localparam int N = qte_pkg::SQRT_STEPS;

  logic                       v    [0:N];
  logic [qte_pkg::RAD_W-1:0]  rem  [0:N];
  logic [qte_pkg::RAD_W-1:0]  root [0:N];
  qte_pkg::qte_ops_t          ops  [0:N];

  assign v[0] = vin;
  assign rem[0] = rad;
  assign root[0] = '0;
  assign ops[0] = ops_in;

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [qte_pkg::RAD_W-1:0] BIT = 62'd1 << (2 * (N - 1 - k));
    logic [qte_pkg::RAD_W-1:0] trial;
    assign trial = root[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      ops[k+1] <= ops[k];
      if (rem[k] >= trial) begin
        rem[k+1] <= rem[k] - trial;
        root[k+1] <= (root[k] >> 1) + BIT;
      end else begin
        rem[k+1] <= rem[k];
        root[k+1] <= root[k] >> 1;
      end
    end
  end

  assign vout = v[N];
  assign root_out = $signed({3'b000, root[N][30:0]});
  assign ops_out = ops[N];

endmodule

// ===== rtl/qte_cordic.sv =====
// unrolled cordic vectoring atan2, one register stage per rotation
// depends on qte_pkg
module qte_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              vin,
  input  logic signed [qte_pkg::OP_W-1:0]   y_in,
  input  logic signed [qte_pkg::OP_W-1:0]   x_in,
  output logic                              vout,
  output logic signed [qte_pkg::ANG_W-1:0]  ang
);

  localparam int N = qte_pkg::STAGES_USED;

  logic                              v    [0:N];
  logic                              zero [0:N];
  logic signed [qte_pkg::XY_W-1:0]   xs   [0:N];
  logic signed [qte_pkg::XY_W-1:0]   ys   [0:N];
  logic signed [qte_pkg::ANG_W-1:0]  zs   [0:N];
  logic signed [qte_pkg::XY_W-1:0]   xe, ye;

  assign xe = qte_pkg::XY_W'(x_in);
  assign ye = qte_pkg::XY_W'(y_in);

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= vin;
    end
  end

  always_ff @(posedge clk) begin
    zero[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      xs[0] <= -xe;
      ys[0] <= -ye;
      zs[0] <= (y_in >= 0) ? qte_pkg::PI_Q30 : -qte_pkg::PI_Q30;
    end else begin
      xs[0] <= xe;
      ys[0] <= ye;
      zs[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [qte_pkg::ANG_W-1:0] ATN = qte_pkg::atan_q30(i);
    logic signed [qte_pkg::XY_W-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      zero[i+1] <= zero[i];
      if (ys[i] >= 0) begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + ATN;
      end else begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - ATN;
      end
    end
  end

  assign vout = v[N];
  assign ang = zero[N] ? '0 : zs[N];

endmodule

// ===== rtl/quaternion_to_euler_angles.sv =====
// throughput: one item per cycle; busy is tied low, the pipeline never stalls
// the receiver cannot stall: done and the angles are shown for exactly one cycle
// reset: synchronous active-high rst clears all valid bits; payload is not reset
// depth is set by the front end, the 31-step square root, the cordic stages and the output register
module quaternion_to_euler_angles (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               done,
  output logic signed [15:0] yaw_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] roll_angle
);

  // front end: products, sums, clamp, radicand (three stages)
  logic                            f_v;
  logic [qte_pkg::RAD_W-1:0]       f_rad;
  qte_pkg::qte_ops_t               f_ops;

  // square root: cosine of pitch, operands delayed alongside
  logic                            s_v;
  logic signed [qte_pkg::OP_W-1:0] s_root;
  qte_pkg::qte_ops_t               s_ops;

  // three parallel atan2 units
  logic                             yaw_v, pitch_v, roll_v;
  logic signed [qte_pkg::ANG_W-1:0] yaw_z, pitch_z, roll_z;

  // rounding to q2.13
  logic signed [35:0] yaw_sum, pitch_sum, roll_sum;
  logic signed [18:0] yaw_r, pitch_r, roll_r;
  logic signed [15:0] yaw_next, roll_next;
  logic signed [14:0] pitch_next;

  // items are always taken
  assign busy = 1'b0;

  qte_front u_front (
    .clk  (clk),
    .rst  (rst),
    .vin  (start),
    .qw   (quat_w),
    .qx   (quat_x),
    .qy   (quat_y),
    .qz   (quat_z),
    .vout (f_v),
    .rad  (f_rad),
    .ops  (f_ops)
  );

  qte_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .vin      (f_v),
    .rad      (f_rad),
    .ops_in   (f_ops),
    .vout     (s_v),
    .root_out (s_root),
    .ops_out  (s_ops)
  );

  qte_cordic u_yaw (
    .clk  (clk),
    .rst  (rst),
    .vin  (s_v),
    .y_in (s_ops.yaw_n),
    .x_in (s_ops.yaw_d),
    .vout (yaw_v),
    .ang  (yaw_z)
  );

  // asin(s) as atan2(s, sqrt(1 - s^2))
  qte_cordic u_pitch (
    .clk  (clk),
    .rst  (rst),
    .vin  (s_v),
    .y_in (s_ops.s),
    .x_in (s_root),
    .vout (pitch_v),
    .ang  (pitch_z)
  );

  qte_cordic u_roll (
    .clk  (clk),
    .rst  (rst),
    .vin  (s_v),
    .y_in (s_ops.roll_n),
    .x_in (s_ops.roll_d),
    .vout (roll_v),
    .ang  (roll_z)
  );

  // round half up from q2.30 to q2.13, then saturate to the angle range
  always_comb begin
    yaw_sum = 36'(yaw_z) + 36'sd65536;
    pitch_sum = 36'(pitch_z) + 36'sd65536;
    roll_sum = 36'(roll_z) + 36'sd65536;
    yaw_r = yaw_sum[35:17];
    pitch_r = pitch_sum[35:17];
    roll_r = roll_sum[35:17];

    if (yaw_r > qte_pkg::ANG_LIMIT) begin
      yaw_next = 16'(qte_pkg::ANG_LIMIT);
    end else if (yaw_r < -qte_pkg::ANG_LIMIT) begin
      yaw_next = 16'(-qte_pkg::ANG_LIMIT);
    end else begin
      yaw_next = yaw_r[15:0];
    end

    if (pitch_r > qte_pkg::PITCH_LIMIT) begin
      pitch_next = 15'(qte_pkg::PITCH_LIMIT);
    end else if (pitch_r < -qte_pkg::PITCH_LIMIT) begin
      pitch_next = 15'(-qte_pkg::PITCH_LIMIT);
    end else begin
      pitch_next = pitch_r[14:0];
    end

    if (roll_r > qte_pkg::ANG_LIMIT) begin
      roll_next = 16'(qte_pkg::ANG_LIMIT);
    end else if (roll_r < -qte_pkg::ANG_LIMIT) begin
      roll_next = 16'(-qte_pkg::ANG_LIMIT);
    end else begin
      roll_next = roll_r[15:0];
    end
  end

  // the three units run in lockstep, so their valid bits agree
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= yaw_v & pitch_v & roll_v;
    end
  end

  always_ff @(posedge clk) begin
    yaw_angle <= yaw_next;
    pitch_angle <= pitch_next;
    roll_angle <= roll_next;
  end

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for quaternion_to_euler_angles
// drives quaternions, predicts zyx euler angles with a cordic model, checks each done strobe
// depends on rtl/qte_pkg.sv and rtl/quaternion_to_euler_angles.sv
`timescale 1ns / 100ps

class euler_scoreboard;
  typedef struct {
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  angles_t pending_angles[$];
  int errors;

  // q2.30 cordic vectoring atan2, mirrors the datapath rules bit for bit
  static function longint cordic_angle(longint ny, longint nx);
    longint ang, dx, dy;
    ang = 0;
    if (nx == 0 && ny == 0) return 0;
    if (nx < 0) begin
      ang = (ny >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      nx = -nx;
      ny = -ny;
    end
    for (int i = 0; i < qte_pkg::STAGES_USED; i++) begin
      dx = ny >>> i;
      dy = nx >>> i;
      if (ny >= 0) begin
        nx += dx;
        ny -= dy;
        ang += longint'(qte_pkg::atan_q30(i));
      end else begin
        nx -= dx;
        ny += dy;
        ang -= longint'(qte_pkg::atan_q30(i));
      end
    end
    return ang;
  endfunction

  // round half up from q2.30 to q2.13 and saturate
  static function longint round_q13(longint a, longint lim);
    longint r;
    r = (a + (64'sd1 << 16)) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // floor square root by bit pairs
  static function longint floor_sqrt(longint unsigned v);
    longint unsigned rem, root, b;
    rem = v;
    root = 0;
    b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem -= root + b;
        root = (root >> 1) + b;
      end else root >>= 1;
      b >>= 2;
    end
    return root;
  endfunction

  function void note_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                          logic signed [15:0] qy, logic signed [15:0] qz);
    longint w, x, y, z, s, c;
    angles_t a;
    w = qw; x = qx; y = qy; z = qz;
    s = -2 * (x * z - w * y);
    if (s > 64'sd1073731087) s = 64'sd1073731087;
    if (s < -64'sd1073741824) s = -64'sd1073741824;
    c = floor_sqrt((64'd1 << 60) - longint'(s * s));
    a.yaw = 16'(round_q13(cordic_angle(2 * (x * y + w * z), w*w + x*x - y*y - z*z), 25736));
    a.pitch = 15'(round_q13(cordic_angle(s, c), 12868));
    a.roll = 16'(round_q13(cordic_angle(2 * (y * z + w * x), w*w - x*x - y*y + z*z), 25736));
    pending_angles.push_back(a);
  endfunction

  function void check_angles(logic signed [15:0] yaw, logic signed [14:0] pitch,
                             logic signed [15:0] roll);
    angles_t e;
    if (pending_angles.size() == 0) begin
      $display("%0t: unexpected result yaw %0d pitch %0d roll %0d", $time, yaw, pitch, roll);
      errors++;
      return;
    end
    e = pending_angles.pop_front();
    if (yaw !== e.yaw) begin
      $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, yaw);
      errors++;
    end
    if (pitch !== e.pitch) begin
      $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch);
      errors++;
    end
    if (roll !== e.roll) begin
      $display("%0t: roll expected %0d actual %0d", $time, e.roll, roll);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic done;
  logic signed [15:0] yaw_angle, roll_angle;
  logic signed [14:0] pitch_angle;

  euler_scoreboard angle_board;
  int gap_pct;          // chance in percent that the sender idles in a cycle
  int stall_count;      // cycles since an item was accepted or a result came out
  bit timed_out;

  localparam int STALL_LIMIT = 2000;

  quaternion_to_euler_angles u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .done(done), .yaw_angle(yaw_angle), .pitch_angle(pitch_angle),
    .roll_angle(roll_angle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // results are sampled at the edge that ends the strobe cycle
  always @(posedge clk) begin
    if (!rst && done) angle_board.check_angles(yaw_angle, pitch_angle, roll_angle);
  end

  // watchdog on accepted items and results
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      timed_out = 1'b1;
      $display("FAIL quaternion_to_euler_angles");
      $finish;
    end
  end

  // present one quaternion, idling first by the current gap rate
  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    bit taken;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    angle_board.note_quat(w, x, y, z);
  endtask

  // mostly near-unit quaternions, sometimes raw noise with full-range bits
  task automatic send_random;
    int sel;
    real a, b, c, d, n;
    sel = $urandom_range(9);
    if (sel < 3) begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      a = $itor($signed(16'($urandom)));
      b = $itor($signed(16'($urandom)));
      c = $itor($signed(16'($urandom)));
      d = $itor($signed(16'($urandom)));
      n = $sqrt(a*a + b*b + c*c + d*d);
      if (n < 1.0) n = 1.0;
      n = 32767.0 / n;
      send_quat(16'($rtoi(a*n)), 16'($rtoi(b*n)), 16'($rtoi(c*n)), 16'($rtoi(d*n)));
    end
  endtask

  initial begin
    angle_board = new();
    gap_pct = 22;
    stall_count = 0;
    timed_out = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, axis rotations, gimbal lock both ways, extremes
    send_quat(16'sd32767, '0, '0, '0);
    send_quat('0, '0, '0, '0);                        // zero vector, yaw and roll atan2 of zero
    send_quat(-16'sd32768, '0, '0, '0);
    send_quat('0, 16'sd32767, '0, '0);                // roll with negative denominator, zero numerator
    send_quat('0, '0, 16'sd32767, '0);
    send_quat('0, '0, '0, 16'sd32767);
    send_quat(16'sd23170, '0, 16'sd23170, '0);        // pitch near +90 degrees, just below the sine clamp
    send_quat(16'sd23170, '0, -16'sd23170, '0);       // pitch near -90 degrees, just above the sine clamp
    send_quat(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);  // non-unit
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_quat(16'sd23170, 16'sd23170, '0, '0);
    send_quat(16'sd23170, '0, '0, -16'sd23170);
    send_quat('0, -16'sd23170, '0, -16'sd23170);
    send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
    send_quat(-16'sd1, '0, '0, '0);
    send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);

    // random in three phases: sender idles lightly, then heavily, then never
    for (int i = 0; i < 300; i++) send_random();
    gap_pct = 69;
    for (int i = 0; i < 300; i++) send_random();
    gap_pct = 0;
    for (int i = 0; i < 300; i++) send_random();
    start <= 1'b0;

    while (angle_board.pending_angles.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (angle_board.errors == 0 && !timed_out) begin
      $display("PASS quaternion_to_euler_angles");
    end else begin
      $display("FAIL quaternion_to_euler_angles");
    end
    $finish;
  end
endmodule
